// ----- rtl/first_fit_heap_allocator_defines.svh -----
// assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
// implication checked on every clock edge outside reset
`define FFH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// implication checked in the cycle after the antecedent
`define FFH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/ffh_pkg.sv -----
// ----------------------------------------------------------------------------
// ffh_pkg
// types and constants shared by the heap allocator
// ----------------------------------------------------------------------------
package ffh_pkg;
  localparam int HEAP_BYTES_DEF = 4096;
  localparam int SMALL_BUCKET_BYTES_DEF = 584;
  localparam int ALIGN_BYTES_DEF = 2;
  localparam logic [15:0] IN_USE = 16'h8000;
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE = 2'd1;
  localparam logic [1:0] REQ_KICK = 2'd2;
  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam logic [0:0] CFG_SMALL_LIMIT = 1'd0;
  localparam logic [0:0] CFG_SPLIT_MIN = 1'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] request_bytes;
    logic [11:0] block_address;
  } ffh_in_t;

  typedef struct packed {
    logic [11:0] granted_address;
    logic        granted;
  } ffh_out_t;
endpackage

// ----- rtl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap manager with lazy coalescing over a header memory
// ----------------------------------------------------------------------------
// channel  | ports                      | handshake
// input    | in_word                    | start and not busy
// result   | out_word                   | out_strobe, one cycle
// config   | cfg_we, cfg_index, cfg_data| cfg_we, no wait
// an allocation reads its first header in S_RD, S_WAIT, S_EVAL, each further
// one in S_NEXT, S_NXTWAIT, S_NXTCHK, S_EVAL, ends in S_SPLIT on a fit, S_FIN,
// S_DONE, set by the one header memory port. free runs S_FREE_RD, S_FREE_WAIT,
// S_FREE_WR, S_DONE, kick one walk. after reset a clearing pass writes the
// reset headers; busy is high meanwhile. the result side never stalls.
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator
  import ffh_pkg::*;
#(
  parameter int HEAP_BYTES = HEAP_BYTES_DEF,
  parameter int SMALL_BUCKET_BYTES = SMALL_BUCKET_BYTES_DEF,
  parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  ffh_in_t     in_word,
  output logic        out_strobe,
  output ffh_out_t    out_word,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  localparam int WORDS = HEAP_BYTES / 2;
  localparam int AW = $clog2(WORDS);
  localparam logic [AW-1:0] BARRIER = AW'(SMALL_BUCKET_BYTES / 2);
  localparam logic [AW-1:0] BIG = AW'(SMALL_BUCKET_BYTES / 2 + 1);
  localparam logic [AW-1:0] LAST = AW'(WORDS - 1);
  localparam logic [14:0] WILD = 15'(HEAP_BYTES - SMALL_BUCKET_BYTES - 4);
  localparam int SW = 18;
  localparam int RK = SW + 3;
  localparam logic [RK:0] RECIP = (RK+1)'(((1 << RK) + ALIGN_BYTES - 1) / ALIGN_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_WAIT, S_EVAL, S_NEXT, S_NXTWAIT, S_NXTCHK,
    S_SPLIT, S_FIN, S_FREE_RD, S_FREE_WAIT, S_FREE_WR, S_DONE
  } state_t;

  // header memory
  logic [15:0] mem [WORDS];
  logic [15:0] rdata_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  state_t state_r, state_nxt;
  logic [AW-1:0] ff_r, ff_nxt;
  logic kicked_r, kicked_nxt;
  logic [11:0] lim_r;
  logic [6:0] smin_r;
  logic [AW:0] h_r, h_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [14:0] prevlen_r, prevlen_nxt;
  logic coal_r, coal_nxt;
  logic [AW:0] steps_r, steps_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [14:0] len_r, len_nxt;
  logic kick_r, kick_nxt;
  logic ok_r, ok_nxt;
  logic [AW:0] clr_r, clr_nxt;
  ffh_out_t res_r, res_nxt;
  logic strobe_r, strobe_nxt;

  // padded size of the incoming request, remainder by reciprocal product
  logic [SW-1:0] sz0, sz1, rem, quo;
  logic [SW+RK:0] prod;
  always_comb begin
    sz0 = SW'(in_word.request_bytes) + SW'(2);
    prod = (SW+RK+1)'(sz0) * (SW+RK+1)'(RECIP);
    quo = prod[RK +: SW];
    rem = sz0 - quo * SW'(ALIGN_BYTES);
    sz1 = (rem != '0) ? sz0 + SW'(ALIGN_BYTES) - rem : sz0;
    sz1 = sz1 + SW'(sz1[0]);
  end

  // header index of a free word
  logic [15:0] fidx;
  assign fidx = 16'(in_word.block_address[11:1]) - 16'd1;

  // adders of the walk: coalesced length and next header index
  logic [15:0] merged;
  logic [15:0] step_h;
  assign merged = {1'b0, prevlen_r + rdata_r[14:0]};
  assign step_h = 16'(h_r) + {2'b00, rdata_r[14:1]};

  // found block index and commit of an allocation
  logic [AW-1:0] blk_r;
  logic [14:0] blen_r;
  logic split_r;
  always_ff @(posedge clk) begin
    if (state_r == S_SPLIT) begin
      blk_r <= h_r[AW-1:0]; blen_r <= len_r;
      split_r <= SW'(len_r) - size_r >= SW'(smin_r) && SW'(len_r) >= size_r;
    end
  end

  logic [14:0] flen;
  logic [15:0] fin_wdata;
  logic [15:0] ff_end;
  assign flen = split_r ? size_r[14:0] : blen_r;
  assign fin_wdata = kick_r ? {1'b0, flen} : (IN_USE | {1'b0, flen});
  assign ff_end = 16'(blk_r) + 16'(flen[14:1]);

  always_comb begin
    state_nxt = state_r; ff_nxt = ff_r; kicked_nxt = kicked_r;
    h_nxt = h_r; prev_nxt = prev_r; prevlen_nxt = prevlen_r; coal_nxt = coal_r;
    steps_nxt = steps_r; size_nxt = size_r; len_nxt = len_r; kick_nxt = kick_r;
    ok_nxt = ok_r; clr_nxt = clr_r; res_nxt = res_r; strobe_nxt = 1'b0;
    raddr = h_r[AW-1:0]; we = 1'b0; waddr = h_r[AW-1:0]; wdata = '0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r[AW-1:0];
        if (clr_r[AW-1:0] == '0) wdata = 16'(SMALL_BUCKET_BYTES);
        else if (clr_r[AW-1:0] == BARRIER) wdata = IN_USE | 16'd2;
        else if (clr_r[AW-1:0] == BIG) wdata = {1'b0, WILD};
        clr_nxt = clr_r + 1'b1;
        if (clr_r[AW-1:0] == LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          coal_nxt = 1'b0; steps_nxt = '0; res_nxt = '0; kick_nxt = 1'b0;
          case (in_word.req_type)
            REQ_ALLOC: begin
              size_nxt = sz1;
              h_nxt = (!kicked_r || sz1 <= SW'(lim_r)) ? {1'b0, ff_r} : {1'b0, BIG};
              state_nxt = (sz1 == '0 || sz1 > SW'(HEAP_BYTES)) ? S_DONE : S_RD;
            end
            REQ_FREE: begin
              res_nxt.granted = 1'b1;
              h_nxt = fidx[AW:0];
              state_nxt = (in_word.block_address[11:1] == '0 ||
                           fidx >= 16'(WORDS)) ? S_DONE : S_FREE_RD;
            end
            REQ_KICK: begin
              kick_nxt = 1'b1;
              // padded size of a 1-byte probe
              size_nxt = SW'((((3 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES + 1) / 2 * 2);
              h_nxt = (!kicked_r || size_nxt <= SW'(lim_r)) ? {1'b0, ff_r} : {1'b0, BIG};
              state_nxt = S_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD: state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_NEXT;
        if (rdata_r[15]) begin
          coal_nxt = 1'b0;
        end else if (coal_r) begin
          we = 1'b1; waddr = prev_r; wdata = merged & 16'h7FFF;
          prevlen_nxt = merged[14:0];
          if (SW'(merged[14:0]) >= size_r) begin
            h_nxt = {1'b0, prev_r}; len_nxt = merged[14:0]; state_nxt = S_SPLIT;
          end
        end else begin
          if (SW'(rdata_r[14:0]) >= size_r) begin
            len_nxt = rdata_r[14:0]; state_nxt = S_SPLIT;
          end else begin
            coal_nxt = 1'b1; prev_nxt = h_r[AW-1:0]; prevlen_nxt = rdata_r[14:0];
          end
        end
        // a step past the heap end saturates so that the walk stops
        if (state_nxt == S_NEXT) begin
          h_nxt = (step_h >= 16'(WORDS)) ? (AW+1)'(WORDS) : step_h[AW:0];
        end
        steps_nxt = steps_r + 1'b1;
      end
      S_NEXT: begin
        raddr = h_r[AW-1:0];
        if (h_r >= (AW+1)'(WORDS)) state_nxt = S_FIN;
        else state_nxt = S_NXTWAIT;
      end
      S_NXTWAIT: state_nxt = S_NXTCHK;
      S_NXTCHK: begin
        if (rdata_r == '0 || steps_r >= (AW+1)'(WORDS)) state_nxt = S_FIN;
        else state_nxt = S_EVAL;
      end
      S_SPLIT: begin
        ok_nxt = 1'b1;
        if (SW'(len_r) - size_r >= SW'(smin_r) && SW'(len_r) >= size_r) begin
          h_nxt = h_r + (AW+1)'(size_r[SW-1:1]);
          waddr = h_nxt[AW-1:0]; wdata = {1'b0, 15'(SW'(len_r) - size_r)};
          we = h_nxt < (AW+1)'(WORDS);
          len_nxt = size_r[14:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // write the found header and move the first-free index
        if (ok_r) begin
          we = 1'b1; waddr = blk_r; wdata = fin_wdata;
          if (kick_r) begin
            ff_nxt = blk_r;
          end else if (kicked_r && ff_r == blk_r && ff_end < 16'(WORDS)) begin
            ff_nxt = ff_end[AW-1:0];
          end
        end
        if (kick_r) begin
          res_nxt.granted = 1'b1;
        end else if (ok_r) begin
          res_nxt.granted = 1'b1;
          res_nxt.granted_address = 12'({({1'b0, blk_r} + 1'b1), 1'b0});
        end
        state_nxt = S_DONE;
      end
      S_FREE_RD: state_nxt = S_FREE_WAIT;
      S_FREE_WAIT: state_nxt = S_FREE_WR;
      S_FREE_WR: begin
        we = 1'b1; wdata = rdata_r & 16'h7FFF;
        if (ff_r > h_r[AW-1:0]) ff_nxt = h_r[AW-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        strobe_nxt = 1'b1; state_nxt = S_IDLE; ok_nxt = 1'b0;
        if (kick_r) kicked_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; ff_r <= '0; kicked_r <= 1'b0;
      lim_r <= 12'd16; smin_r <= 7'd4; strobe_r <= 1'b0; ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; ff_r <= ff_nxt; kicked_r <= kicked_nxt;
      strobe_r <= strobe_nxt; ok_r <= ok_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_SMALL_LIMIT) lim_r <= cfg_data;
        else smin_r <= cfg_data[6:0];
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    h_r <= h_nxt; prev_r <= prev_nxt; prevlen_r <= prevlen_nxt; coal_r <= coal_nxt;
    steps_r <= steps_nxt; size_r <= size_nxt; len_r <= len_nxt; kick_r <= kick_nxt;
    res_r <= res_nxt;
  end

  assign busy = state_r != S_IDLE;
  assign out_strobe = strobe_r;
  assign out_word = res_r;

  `FFH_ASSERT_IMP(a_strobe_idle, out_strobe, state_r == S_IDLE, "strobe outside idle")
  `FFH_ASSERT_NXT(a_start_busy, start && !busy, busy, "start not taken")
  `FFH_ASSERT_IMP(a_fail_zero, out_strobe && !out_word.granted,
                  out_word.granted_address == '0, "failed result has address")
endmodule
